// ===== rtl/core/atp_pkg.sv =====
`timescale 1ns / 1ps

package atp_pkg;

  // Configuration register geometry
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 2;
  localparam int DEC_W   = 5;
  localparam int CNT_W   = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 2'd2;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] LOW_RESET   = 18'd20000;
  localparam logic [CFG_W-1:0] HIGH_RESET  = 18'd100000;
  localparam logic [DEC_W-1:0] DECIM_RESET = 5'd5;

  // Decimation saturates here
  localparam logic [DEC_W-1:0] DECIM_MAX = 5'd16;

  // Status of the queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/core/atp_fifo.sv =====
`timescale 1ns / 1ps

module atp_fifo import atp_pkg::*; #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output fifo_stat_t       stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_F = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0]   mem_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r;
  logic [PTR_W-1:0]   rptr_r;
  logic [CNT_W_F-1:0] count_r;
  logic [CNT_W_F-1:0] count_nxt;

  assign stat.full  = (count_r == CNT_W_F'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem_r[rptr_r];

  // Track fill level
  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W_F'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CNT_W_F'(1);
    end
  end

  // Advance pointers and hold entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) begin
        mem_r[wptr_r] <= wr_data;
        wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
      end
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W_F'(DEPTH))
    else $error("queue fill level beyond depth");

endmodule

// ===== rtl/core/atp_front.sv =====
`timescale 1ns / 1ps

module atp_front import atp_pkg::*; #(
  parameter int WINDOW_LEN  = 8,
  parameter int SAMPLE_BITS = 18
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_push,
  input  logic [SAMPLE_BITS-1:0]                    in_sample,
  output logic                                      in_full,
  input  logic [DEC_W-1:0]                          decimation,
  input  fifo_stat_t                                stat,
  output logic                                      wr_en,
  output logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] wr_sum
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

  logic [SAMPLE_BITS-1:0] win_r [WINDOW_LEN];
  logic [SLOT_W-1:0]      slot_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [DEC_W-1:0]       dec_eff;
  logic [DEC_W-1:0]       cnt_inc;
  logic                   accept;
  logic                   emit;

  assign in_full = stat.full;
  assign accept  = in_push && !stat.full;

  // Clamp decimation to one .. sixteen
  always_comb begin
    priority if (decimation == '0) begin
      dec_eff = DEC_W'(1);
    end else if (decimation > DECIM_MAX) begin
      dec_eff = DECIM_MAX;
    end else begin
      dec_eff = decimation;
    end
  end

  assign cnt_inc = DEC_W'(cnt_r) + DEC_W'(1);
  assign emit    = (cnt_inc >= dec_eff);

  // Running window sum: drop the oldest entry, add the new sample
  assign sum_nxt = sum_r - SUM_W'(win_r[slot_r]) + SUM_W'(in_sample);

  assign wr_en  = accept && emit;
  assign wr_sum = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
      slot_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      win_r[slot_r] <= in_sample;
      slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
      sum_r  <= sum_nxt;
      cnt_r  <= emit ? '0 : CNT_W'(cnt_inc);
    end
  end

endmodule

// ===== rtl/core/atp_div.sv =====
`timescale 1ns / 1ps

module atp_div #(
  parameter int N = 24,
  parameter int M = 18
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CNT_W_D = $clog2(N + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W_D-1:0] cnt_r;
  logic [N-1:0]       dq_r;
  logic [M-1:0]       dvs_r;
  logic [M-1:0]       rem_r;
  logic [M:0]         trial;
  logic               ge;
  logic [M-1:0]       rem_nxt;
  logic [N-1:0]       dq_nxt;

  assign done     = done_r;
  assign quotient = dq_r;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial   = {rem_r, dq_r[N-1]};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? M'(trial - {1'b0, dvs_r}) : M'(trial);
  assign dq_nxt  = {dq_r[N-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // Flag completion for one cycle after the last step
      done_r <= busy_r && !start && (cnt_r == CNT_W_D'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W_D'(N);
        dq_r   <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dq_r  <= dq_nxt;
        cnt_r <= cnt_r - CNT_W_D'(1);
        if (cnt_r == CNT_W_D'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

endmodule

// ===== rtl/core/atp_back.sv =====
`timescale 1ns / 1ps

module atp_back import atp_pkg::*; #(
  parameter int WINDOW_LEN   = 8,
  parameter int DISPLAY_COLS = 128,
  parameter int DISPLAY_ROWS = 64,
  parameter int SAMPLE_BITS  = 18
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  fifo_stat_t                                stat,
  input  logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0] rd_sum,
  output logic                                      rd_en,
  input  logic [CFG_W-1:0]                          low_level,
  input  logic [CFG_W-1:0]                          high_level,
  output logic                                      out_empty,
  input  logic                                      out_pop,
  output logic [$clog2(DISPLAY_COLS)-1:0]           out_x_column,
  output logic [$clog2(DISPLAY_ROWS)-1:0]           out_y_row,
  output logic                                      out_clear_after
);

  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int ROW_W   = $clog2(DISPLAY_ROWS);
  localparam int COL_W   = $clog2(DISPLAY_COLS);
  localparam int PROD_W  = SAMPLE_BITS + ROW_W;
  localparam int DIV_N   = PROD_W;
  localparam int WIN_SH  = $clog2(WINDOW_LEN);
  localparam int MEAN_SH = SUM_W + WIN_SH;
  localparam int MUL_W   = SUM_W + 1;
  localparam int MPROD_W = 2 * SUM_W + 1;
  // Rounded-up reciprocal of the window length, exact for every window sum
  localparam longint MEAN_RECIP =
    ((longint'(1) << MEAN_SH) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
  localparam logic [MUL_W-1:0] MEAN_MUL = MUL_W'(MEAN_RECIP);
  localparam logic [ROW_W-1:0] ROW_TOP  = ROW_W'(DISPLAY_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(DISPLAY_COLS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  state_t                 state_r;
  logic [SAMPLE_BITS-1:0] level_r;
  logic [SAMPLE_BITS-1:0] span_r;
  logic [PROD_W-1:0]      prod_r;
  logic [ROW_W-1:0]       row_r;
  logic                   div_start_r;
  logic [COL_W-1:0]       col_r;
  logic                   out_valid_r;
  logic [COL_W-1:0]       out_col_r;
  logic [ROW_W-1:0]       out_row_r;
  logic                   out_clr_r;

  logic [SAMPLE_BITS-1:0] lo;
  logic [SAMPLE_BITS-1:0] hi;
  logic                   span_ok;
  logic [SAMPLE_BITS-1:0] lvl_clamp;
  logic [SAMPLE_BITS-1:0] diff;
  logic [PROD_W-1:0]      prod_nxt;
  logic [MPROD_W-1:0]     mean_prod;
  logic [SAMPLE_BITS-1:0] mean_val;
  logic [DIV_N-1:0]       div_dividend;
  logic [SAMPLE_BITS-1:0] div_divisor;
  logic                   div_done;
  logic [DIV_N-1:0]       div_quo;
  logic                   out_free;

  assign out_empty       = !out_valid_r;
  assign out_x_column    = out_col_r;
  assign out_y_row       = out_row_r;
  assign out_clear_after = out_clr_r;

  // Levels masked to the sample width
  assign lo      = SAMPLE_BITS'(low_level);
  assign hi      = SAMPLE_BITS'(high_level);
  assign span_ok = (hi > lo);

  // Clamp the mean to the level range and scale by the top row
  always_comb begin
    priority if (level_r < lo) begin
      lvl_clamp = lo;
    end else if (level_r > hi) begin
      lvl_clamp = hi;
    end else begin
      lvl_clamp = level_r;
    end
  end

  assign diff     = lvl_clamp - lo;
  assign prod_nxt = PROD_W'(diff) * PROD_W'(DISPLAY_ROWS - 1);

  // Floor mean of the window by a constant reciprocal multiply
  assign mean_prod = MPROD_W'(rd_sum) * MPROD_W'(MEAN_MUL);
  assign mean_val  = SAMPLE_BITS'(mean_prod >> MEAN_SH);

  // Divider scales the clamped level by the span
  assign div_dividend = prod_r;
  assign div_divisor  = span_r;

  assign rd_en    = (state_r == S_IDLE) && !stat.empty;
  assign out_free = !out_valid_r || out_pop;

  atp_div #(
    .N (DIV_N),
    .M (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequence one plot point: mean, scale, divide (or take ROW_TOP when high is not above low), hand over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == S_MUL) && span_ok;
      out_valid_r <= ((state_r == S_OUT) && out_free) || (out_valid_r && !out_pop);
      unique case (state_r)
        S_IDLE: begin
          if (rd_en) begin
            level_r <= mean_val;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= prod_nxt;
          span_r <= hi - lo;
          if (span_ok) begin
            state_r <= S_DIV;
          end else begin
            row_r   <= ROW_TOP;
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            row_r   <= ROW_TOP - ROW_W'(div_quo);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_col_r <= col_r;
            out_row_r <= row_r;
            out_clr_r <= (col_r == COL_LAST);
            col_r     <= (col_r == COL_LAST) ? '0 : col_r + COL_W'(1);
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished with no division pending");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done && state_r == S_DIV) |-> (div_quo <= DIV_N'(DISPLAY_ROWS - 1)))
    else $error("scaled row beyond display height");

  a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !stat.empty)
    else $error("queue read while empty");

endmodule

// ===== rtl/core/averaged_trace_plotter.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Payload
// in_       input      in_push/in_full  in_ir_sample
// out_      output     out_empty/pop    out_x_column, out_y_row, out_clear_after
// cfg_      input      cfg_we           cfg_index, cfg_data
//
// A sample is taken whenever the two-entry point queue has room. In the back
// end a plot point is scaled by the bit-serial divider when high exceeds low;
// the window mean is a constant reciprocal multiply in the cycle the point
// leaves the queue.
// Reset is synchronous, active low, and clears the window, counters and sweep.
// A result held on the output does not block the back end until the next
// point is ready; a full point queue raises in_full.

module averaged_trace_plotter import atp_pkg::*; #(
  parameter int WINDOW_LEN   = 8,
  parameter int DISPLAY_COLS = 128,
  parameter int DISPLAY_ROWS = 64,
  parameter int SAMPLE_BITS  = 18
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [SAMPLE_BITS-1:0]          in_ir_sample,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [$clog2(DISPLAY_COLS)-1:0] out_x_column,
  output logic [$clog2(DISPLAY_ROWS)-1:0] out_y_row,
  output logic                            out_clear_after,
  input  logic                            cfg_we,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_W-1:0]                cfg_data
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);

  logic [CFG_W-1:0] low_r;
  logic [CFG_W-1:0] high_r;
  logic [DEC_W-1:0] decim_r;

  fifo_stat_t       q_stat;
  logic             q_wr;
  logic [SUM_W-1:0] q_wr_sum;
  logic             q_rd;
  logic [SUM_W-1:0] q_rd_sum;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= LOW_RESET;
      high_r  <= HIGH_RESET;
      decim_r <= DECIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_LEVEL:  low_r   <= cfg_data;
        CFG_HIGH_LEVEL: high_r  <= cfg_data;
        CFG_DECIMATION: decim_r <= cfg_data[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  atp_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_sample  (in_ir_sample),
    .in_full    (in_full),
    .decimation (decim_r),
    .stat       (q_stat),
    .wr_en      (q_wr),
    .wr_sum     (q_wr_sum)
  );

  atp_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (2)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wr_sum),
    .rd_en   (q_rd),
    .rd_data (q_rd_sum),
    .stat    (q_stat)
  );

  atp_back #(
    .WINDOW_LEN   (WINDOW_LEN),
    .DISPLAY_COLS (DISPLAY_COLS),
    .DISPLAY_ROWS (DISPLAY_ROWS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .stat            (q_stat),
    .rd_sum          (q_rd_sum),
    .rd_en           (q_rd),
    .low_level       (low_r),
    .high_level      (high_r),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_x_column    (out_x_column),
    .out_y_row       (out_y_row),
    .out_clear_after (out_clear_after)
  );

endmodule
